>>> hw/rtl/smx_pkg.sv
// Shared types and constants for the stack machine executor.
// No dependencies; every other file imports this package.
package smx_pkg;

  localparam int unsigned StackDepth   = 64;
  localparam int unsigned DataWidth    = 32;
  localparam int unsigned FuncWidth    = 3;
  localparam int unsigned OperandWidth = 32;
  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned DepthWidth   = 7;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned SpWidth      = $clog2(StackDepth + 1);
  localparam int unsigned AddrWidth    = $clog2(StackDepth);
  localparam int unsigned DivCntWidth  = $clog2(DataWidth);

  typedef enum logic [FuncWidth-1:0] {
    FUNC_PUSH = 3'd0,
    FUNC_POP  = 3'd1,
    FUNC_ADD  = 3'd2,
    FUNC_SUB  = 3'd3,
    FUNC_MUL  = 3'd4,
    FUNC_DIV  = 3'd5
  } func_e;

  typedef enum logic [StatusWidth-1:0] {
    STS_OK    = 2'd0,
    STS_UNDER = 2'd1,
    STS_OVER  = 2'd2,
    STS_DIVZ  = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic div_start;
    logic div_take;
    logic commit;
  } smx_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_div;
    logic div_done;
  } smx_sts_t;

endpackage

>>> hw/rtl/smx_req_if.sv
// Request channel: valid/ready handshake carrying one instruction.
// Depends on smx_pkg.
interface smx_req_if
  import smx_pkg::*;
();
  logic                           valid;
  logic                           ready;
  logic [FuncWidth-1:0]           func;
  logic signed [OperandWidth-1:0] operand;

  modport source (output valid, func, operand, input ready);
  modport sink   (input valid, func, operand, output ready);
endinterface

>>> hw/rtl/smx_rsp_if.sv
// Response channel: valid/ready handshake carrying one instruction result.
// Depends on smx_pkg.
interface smx_rsp_if
  import smx_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [ValueWidth-1:0] value;
  logic [DepthWidth-1:0]        depth;
  logic [StatusWidth-1:0]       status;

  modport source (output valid, value, depth, status, input ready);
  modport sink   (input valid, value, depth, status, output ready);
endinterface

>>> hw/rtl/smx_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on smx_pkg.
module smx_div
  import smx_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DataWidth-1:0] dividend_i,
  input  logic [DataWidth-1:0] divisor_i,
  output logic                 done_o,
  output logic [DataWidth-1:0] quotient_o
);

  logic                   busy_q;
  logic                   done_q;
  logic [DivCntWidth-1:0] cnt_q;
  logic [DataWidth-1:0]   rem_q;
  logic [DataWidth-1:0]   dvd_q;
  logic [DataWidth-1:0]   dsr_q;
  logic                   neg_q;

  logic [DataWidth:0]     rem_sh;
  logic                   qbit;
  logic [DataWidth:0]     rem_sub;
  logic [DataWidth-1:0]   mag_a;
  logic [DataWidth-1:0]   mag_b;

  assign mag_a   = dividend_i[DataWidth-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign mag_b   = divisor_i[DataWidth-1]  ? (~divisor_i + 1'b1)  : divisor_i;
  assign rem_sh  = {rem_q, dvd_q[DataWidth-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign qbit    = ~rem_sub[DataWidth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntWidth'(DataWidth - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= mag_a;
      dsr_q <= mag_b;
      neg_q <= dividend_i[DataWidth-1] ^ divisor_i[DataWidth-1];
    end else if (busy_q) begin
      rem_q <= qbit ? rem_sub[DataWidth-1:0] : rem_sh[DataWidth-1:0];
      dvd_q <= {dvd_q[DataWidth-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~dvd_q + 1'b1) : dvd_q;

endmodule

>>> hw/rtl/smx_datapath.sv
// Datapath: stack memory, cached top of stack, ALU, result register, divider.
// Depends on smx_pkg and smx_div; driven by smx_ctrl commands.
module smx_datapath
  import smx_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  smx_cmd_t                cmd_i,
  output smx_sts_t                sts_o,
  input  logic [FuncWidth-1:0]    func_i,
  input  logic [OperandWidth-1:0] operand_i,
  output logic [ValueWidth-1:0]   value_o,
  output logic [DepthWidth-1:0]   depth_o,
  output logic [StatusWidth-1:0]  status_o
);

  // entries below the top live in mem; the top itself is held in top_q
  logic [DataWidth-1:0]   mem [StackDepth];
  logic [DataWidth-1:0]   rdata_q;

  logic [SpWidth-1:0]     sp_q, sp_d;
  logic [DataWidth-1:0]   top_q, top_d;
  logic [FuncWidth-1:0]   func_q;
  logic [DataWidth-1:0]   opnd_q;
  logic [DataWidth-1:0]   res_q;
  logic [ValueWidth-1:0]  value_q, value_d;
  logic [DepthWidth-1:0]  depth_q;
  logic [StatusWidth-1:0] status_q;

  status_e                sts;
  logic                   is_empty;
  logic                   has_two;
  logic                   is_full;
  logic [DataWidth-1:0]   top_or0;
  logic                   mem_we;
  logic [AddrWidth-1:0]   waddr;
  logic [AddrWidth-1:0]   raddr;
  logic                   div_done;
  logic [DataWidth-1:0]   div_quo;
  logic [DataWidth-1:0]   opnd_ext;

  assign is_empty = (sp_q == '0);
  assign has_two  = (sp_q >= SpWidth'(2));
  assign is_full  = (sp_q >= SpWidth'(StackDepth));
  assign top_or0  = is_empty ? '0 : top_q;
  assign raddr    = AddrWidth'(sp_q - SpWidth'(2));
  assign waddr    = AddrWidth'(sp_q - SpWidth'(1));
  assign opnd_ext = DataWidth'(signed'(operand_i));

  always_comb begin
    sts = STS_OK;
    unique case (func_e'(func_q))
      FUNC_PUSH: if (is_full) sts = STS_OVER;
      FUNC_POP:  if (is_empty) sts = STS_UNDER;
      FUNC_ADD, FUNC_SUB, FUNC_MUL: if (!has_two) sts = STS_UNDER;
      FUNC_DIV: begin
        if (!has_two) sts = STS_UNDER;
        else if (top_q == '0) sts = STS_DIVZ;
      end
      default: sts = STS_OK;
    endcase
  end

  // commit values
  always_comb begin
    sp_d    = sp_q;
    top_d   = top_q;
    mem_we  = 1'b0;
    value_d = ValueWidth'(top_or0);
    unique case (func_e'(func_q))
      FUNC_PUSH: begin
        if (sts == STS_OK) begin
          sp_d    = sp_q + SpWidth'(1);
          top_d   = opnd_q;
          mem_we  = !is_empty;
          value_d = ValueWidth'(opnd_q);
        end
      end
      FUNC_POP: begin
        if (sts == STS_OK) begin
          sp_d    = sp_q - SpWidth'(1);
          top_d   = rdata_q;
          value_d = ValueWidth'(top_q);
        end else begin
          value_d = '0;
        end
      end
      FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
        if (sts == STS_OK) begin
          sp_d    = sp_q - SpWidth'(1);
          top_d   = res_q;
          value_d = ValueWidth'(res_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else if (cmd_i.commit) begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && cmd_i.commit) begin
      mem[waddr] <= top_q;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      opnd_q <= opnd_ext;
    end
    if (cmd_i.exec) begin
      unique case (func_e'(func_q))
        FUNC_ADD: res_q <= rdata_q + top_q;
        FUNC_SUB: res_q <= rdata_q - top_q;
        FUNC_MUL: res_q <= DataWidth'(rdata_q * top_q);
        default:  res_q <= res_q;
      endcase
    end else if (cmd_i.div_take) begin
      res_q <= div_quo;
    end
    if (cmd_i.commit) begin
      top_q    <= top_d;
      value_q  <= value_d;
      depth_q  <= DepthWidth'(sp_d);
      status_q <= sts;
    end
  end

  smx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rdata_q),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign sts_o.needs_div = (func_e'(func_q) == FUNC_DIV) && (sts == STS_OK);
  assign sts_o.div_done  = div_done;

  assign value_o  = value_q;
  assign depth_o  = depth_q;
  assign status_o = status_q;

endmodule

>>> hw/rtl/smx_ctrl.sv
// Controller: sequences one instruction at a time and owns the response valid.
// Depends on smx_pkg; commands smx_datapath.
module smx_ctrl
  import smx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  input  smx_sts_t sts_i,
  output smx_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && req_valid_i;
    cmd_o.exec      = (state_q == ST_EXEC);
    cmd_o.div_start = (state_q == ST_EXEC) && sts_i.needs_div;
    cmd_o.div_take  = (state_q == ST_DIV) && sts_i.div_done;
    cmd_o.commit    = (state_q == ST_FIN) && out_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    unique case (state_q)
      ST_IDLE: if (req_valid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = sts_i.needs_div ? ST_DIV : ST_FIN;
      ST_DIV:  if (sts_i.div_done) state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

endmodule

>>> hw/rtl/stack_machine_executor_core.sv
// Stack machine executor, top level: controller plus datapath.
// Depends on smx_pkg, smx_req_if, smx_rsp_if, smx_ctrl, smx_datapath.
//
// Usage:
//   req_i carries one instruction per request (func, operand); rsp_o returns
//   exactly one result per request (value, depth, status), in order.
//   Requests are taken one at a time: req_i.ready is high only while the
//   core is idle.
//   The response becomes valid when the result is committed, after the
//   EXEC and FIN states; a division also waits in the DIV state for the
//   one-bit-per-cycle divider. A new request is taken only once the
//   previous one has been committed and the core is back in IDLE.
//   Results sit in an output register, so the next request is accepted
//   and worked on while a response waits; if the receiver stalls, the
//   core holds the finished result of that next request until the
//   register drains, and stops taking requests.
//   Reset empties the stack (depth 0); stack contents need no clearing.
//   Errors (underflow, overflow, divide by zero) leave the stack untouched.
module stack_machine_executor_core
  import smx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  smx_req_if.sink    req_i,
  smx_rsp_if.source  rsp_o
);

  smx_cmd_t cmd;
  smx_sts_t sts;

  smx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smx_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .func_i    (req_i.func),
    .operand_i (req_i.operand),
    .value_o   (rsp_o.value),
    .depth_o   (rsp_o.depth),
    .status_o  (rsp_o.status)
  );

endmodule

>>> hw/rtl/smx_checker.sv
// Port-level checks for stack_machine_executor_core, attached by bind.
// Depends on smx_pkg.
module smx_checker
  import smx_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid_i,
  input logic                   req_ready_i,
  input logic                   rsp_valid_i,
  input logic                   rsp_ready_i,
  input logic [DepthWidth-1:0]  depth_i,
  input logic [StatusWidth-1:0] status_i
);

  // response waits until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before accept");

  // one request in flight: no back-to-back accepts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STS_OVER) |-> depth_i == DepthWidth'(StackDepth))
    else $error("overflow reported on a stack that is not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STS_UNDER) |-> depth_i < DepthWidth'(2))
    else $error("underflow reported with two or more entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STS_DIVZ) |-> depth_i >= DepthWidth'(2))
    else $error("divide by zero reported with fewer than two entries");

endmodule

bind stack_machine_executor_core smx_checker u_smx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .depth_i     (rsp_o.depth),
  .status_i    (rsp_o.status)
);

>>> sim/tb_stack_machine_executor_core.sv
`timescale 1ns / 100ps
// Self-checking bench for stack_machine_executor_core: a table of directed
// instructions, then mode-driven random programs, checked against a stack model.
// Depends on smx_pkg, smx_req_if, smx_rsp_if and the core RTL.
module tb_stack_machine_executor_core;
  import smx_pkg::*;

  localparam logic [FuncWidth-1:0] FUNC_NOP6 = 3'd6;
  localparam logic [FuncWidth-1:0] FUNC_NOP7 = 3'd7;
  localparam int RandOps   = 1800;
  localparam int MaxCycles = 600_000;
  localparam int LongHold  = 400;
  localparam int DrainWait = 40;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [DepthWidth-1:0]        depth;
    status_e                      status;
  } result_t;

  typedef struct {
    logic [FuncWidth-1:0]           fn;
    logic signed [OperandWidth-1:0] opnd;
    bit                             fixed;
    result_t                        want;
  } dir_row_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BAL} mix_e;

  logic clk = 1'b0;
  logic rst_n;

  smx_req_if req ();
  smx_rsp_if rsp ();

  stack_machine_executor_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the stack
  logic signed [DataWidth-1:0] shadow_stack [StackDepth];
  int unsigned                 shadow_sp;
  int unsigned                 deepest;

  result_t  due_results [$];
  dir_row_t dir_tab [$];

  int  errors = 0;
  int  cycles = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  status_seen [4];
  bit  idling_on = 1'b1;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  function automatic result_t run_instr(logic [FuncWidth-1:0] fn,
                                        logic signed [OperandWidth-1:0] opnd);
    result_t                     res;
    logic signed [DataWidth-1:0] t, n, r;
    longint                      quot;
    status_e                     st;
    st = STS_OK;
    r  = '0;
    case (fn)
      FUNC_PUSH: begin
        if (shadow_sp >= StackDepth) st = STS_OVER;
        else begin
          shadow_stack[shadow_sp] = opnd;
          shadow_sp++;
        end
      end
      FUNC_POP: begin
        if (shadow_sp == 0) st = STS_UNDER;
        else shadow_sp--;
      end
      FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
        if (shadow_sp < 2) st = STS_UNDER;
        else begin
          t = shadow_stack[shadow_sp-1];
          n = shadow_stack[shadow_sp-2];
          case (fn)
            FUNC_ADD: r = n + t;
            FUNC_SUB: r = n - t;
            FUNC_MUL: r = n * t;
            default: begin
              if (t == 0) st = STS_DIVZ;
              else begin
                // 64-bit divide so that min / -1 wraps instead of trapping
                quot = longint'(n) / longint'(t);
                r = quot[DataWidth-1:0];
              end
            end
          endcase
          if (st == STS_OK) begin
            shadow_sp--;
            shadow_stack[shadow_sp-1] = r;
          end
        end
      end
      default: ;
    endcase
    if (fn == FUNC_POP)
      res.value = (st == STS_OK) ? shadow_stack[shadow_sp] : '0;
    else
      res.value = (shadow_sp == 0) ? '0 : shadow_stack[shadow_sp-1];
    res.depth  = shadow_sp[DepthWidth-1:0];
    res.status = st;
    if (shadow_sp > deepest) deepest = shadow_sp;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < 30)
      $display("%0t: MISMATCH %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic add_row(logic [FuncWidth-1:0] fn, logic [OperandWidth-1:0] opnd,
                         bit fixed, logic [ValueWidth-1:0] val = '0,
                         logic [DepthWidth-1:0] dep = '0, status_e st = STS_OK);
    dir_row_t row;
    row.fn          = fn;
    row.opnd        = opnd;
    row.fixed       = fixed;
    row.want.value  = val;
    row.want.depth  = dep;
    row.want.status = st;
    dir_tab.push_back(row);
  endtask

  // Offer one request, wait for the handshake, then log its expected result.
  task automatic send_instr(logic [FuncWidth-1:0] fn, logic signed [OperandWidth-1:0] opnd,
                            bit fixed = 1'b0, result_t fixed_res = '0);
    bit      taken;
    result_t res;
    while (idling_on && $urandom_range(99) < 16) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.func    <= fn;
    req.operand <= opnd;
    // inputs and outputs only move at the rising edge, so the falling edge
    // shows what the next rising edge will see
    do begin
      @(negedge clk);
      taken = req.ready;
      @(posedge clk);
    end while (!taken);
    res = run_instr(fn, opnd);
    due_results.push_back(fixed ? fixed_res : res);
    n_sent++;
  endtask

  function automatic logic signed [OperandWidth-1:0] rand_operand();
    int small_val;
    small_val = int'($urandom_range(40)) - 20;
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'sd1;
      2:       return -32'sd1;
      3:       return 32'h7fff_ffff;
      4:       return 32'h8000_0000;
      5, 6:    return small_val;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FuncWidth-1:0] pick_func(mix_e mode);
    int r, push_pct;
    r = $urandom_range(99);
    push_pct = (mode == MIX_FILL) ? 80 : (mode == MIX_DRAIN) ? 15 : 45;
    if (r < 3) return $urandom_range(1) ? FUNC_NOP6 : FUNC_NOP7;
    if (r < 3 + push_pct) return FUNC_PUSH;
    case ($urandom_range(5))
      0:       return FUNC_POP;
      1:       return FUNC_ADD;
      2:       return FUNC_SUB;
      3:       return FUNC_MUL;
      default: return FUNC_DIV;
    endcase
  endfunction

  // response side: random stalls plus one long hold-off on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= !(idling_on && $urandom_range(99) < 16);
      end
    end
  end

  always @(negedge clk) begin
    result_t want;
    if (rst_n && rsp.valid && rsp.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with no request outstanding", rsp.value, '0);
      end else begin
        want = due_results.pop_front();
        n_checked++;
        status_seen[want.status]++;
        if (rsp.value !== want.value) report_mismatch("value", rsp.value, want.value);
        if (rsp.depth !== want.depth) report_mismatch("depth", rsp.depth, want.depth);
        if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               due_results.size());
      $display("tb_stack_machine_executor_core failed");
      $finish;
    end
  end

  initial begin
    mix_e                           mode;
    int                             seg_left;
    int                             n_ops;
    int                             k;
    logic [FuncWidth-1:0]           fn;
    logic signed [OperandWidth-1:0] opnd;

    rst_n       = 1'b0;
    req.valid   = 1'b0;
    req.func    = FUNC_PUSH;
    req.operand = '0;
    shadow_sp   = 0;
    deepest     = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // fixed rows hold results readable straight off the spec
    add_row(FUNC_POP,  0, 1, 0, 0, STS_UNDER);
    add_row(FUNC_ADD,  0, 1, 0, 0, STS_UNDER);
    add_row(FUNC_NOP6, 0, 1, 0, 0, STS_OK);
    add_row(FUNC_PUSH, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1, STS_OK);
    add_row(FUNC_DIV,  0, 1, 32'h7fff_ffff, 1, STS_UNDER);
    add_row(FUNC_PUSH, 32'h8000_0000, 1, 32'h8000_0000, 2, STS_OK);
    add_row(FUNC_ADD,  0, 1, 32'hffff_ffff, 1, STS_OK);
    add_row(FUNC_PUSH, 0, 1, 0, 2, STS_OK);
    add_row(FUNC_DIV,  0, 1, 0, 2, STS_DIVZ);
    add_row(FUNC_POP,  0, 1, 0, 1, STS_OK);
    add_row(FUNC_PUSH, 32'h8000_0000, 1, 32'h8000_0000, 2, STS_OK);
    add_row(FUNC_PUSH, 32'hffff_ffff, 1, 32'hffff_ffff, 3, STS_OK);
    add_row(FUNC_DIV,  0, 1, 32'h8000_0000, 2, STS_OK);   // min / -1 wraps
    add_row(FUNC_PUSH, 7, 0);
    add_row(FUNC_SUB,  0, 0);
    add_row(FUNC_PUSH, 32'hffff_fffd, 0);
    add_row(FUNC_MUL,  0, 0);
    add_row(FUNC_PUSH, 5, 0);
    add_row(FUNC_DIV,  0, 0);
    add_row(FUNC_PUSH, 32'hffff_fff9, 0);
    add_row(FUNC_PUSH, 2, 0);
    add_row(FUNC_DIV,  0, 0);
    add_row(FUNC_NOP7, 0, 0);
    add_row(FUNC_SUB,  0, 0);
    add_row(FUNC_POP,  0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_instr(dir_tab[i].fn, (dir_tab[i].fn == FUNC_PUSH) ? dir_tab[i].opnd : $urandom(),
                 dir_tab[i].fixed, dir_tab[i].want);

    // random programs; the first segment fills the stack to reach overflow
    mode     = MIX_FILL;
    seg_left = 90;
    n_ops    = 0;
    k        = 0;
    while (n_ops < RandOps) begin
      if (seg_left == 0) begin
        mode     = mix_e'($urandom_range(2));
        seg_left = $urandom_range(20, 80);
      end
      seg_left--;
      idling_on = (k < 600 || k >= 900);
      if (k == 300) hold_req = 1'b1;
      if (k == 1000) begin
        req.valid <= 1'b0;
        wait (due_results.size() == 0);
        @(posedge clk);
      end
      fn   = pick_func(mode);
      opnd = rand_operand();
      send_instr(fn, opnd);
      if (fn != FUNC_NOP6 && fn != FUNC_NOP7) n_ops++;
      k++;
    end
    req.valid <= 1'b0;

    wait (due_results.size() == 0);
    repeat (DrainWait) @(posedge clk);

    $display("Ran %0d instructions (%0d directed), %0d results checked, deepest stack %0d.",
             n_sent, dir_tab.size(), n_checked, deepest);
    $display("Status mix: %0d ok, %0d underflow, %0d overflow, %0d divide by zero; %0d errors.",
             status_seen[STS_OK], status_seen[STS_UNDER], status_seen[STS_OVER],
             status_seen[STS_DIVZ], errors);
    if (errors == 0)
      $display("tb_stack_machine_executor_core passed");
    else
      $display("tb_stack_machine_executor_core failed");
    $finish;
  end

endmodule
